/* rtl/fsa_pkg.sv */
// Shared types and constants of the free-list slot allocator.
`default_nettype none

package fsa_pkg;

  // Field widths of the channels
  localparam int ACTION_W   = 2;
  localparam int INDEX_W    = 16;
  localparam int LINK_W     = 32;
  localparam int RES_W      = 64;
  localparam int STATUS_W   = 2;
  localparam int GRANT_W    = 8;
  localparam int TAG_W      = 16;
  localparam int CAP_W      = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  // Width for capacity compares: covers 16-bit handles and any pool size
  localparam int CMP_W      = 17;

  // Register reset values
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;
  localparam logic [TAG_W-1:0] TAG_RESET = 16'd0;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_CREATE  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ    = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FREE  = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAG      = 1'd1;

  // Released slot payload
  localparam logic [LINK_W-1:0] LINK_CLEARED = '1;
  localparam logic [RES_W-1:0]  RES_CLEARED  = '0;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } fsa_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // capture transaction, launch memory reads
    logic commit;     // apply update, load result register
    logic cfg_write;  // register write
  } fsa_cmd_t;

endpackage

`default_nettype wire

/* rtl/fsa_ctrl.sv */
// Controller state machine: sequencing of transactions and handshakes.
`default_nettype none

module fsa_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  wire              out_stall,
  input  wire              cfg_valid,
  output logic             cfg_ready,
  output fsa_pkg::fsa_cmd_t cmd
);
  import fsa_pkg::*;

  fsa_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_stall      = 1'b1;
    cfg_ready     = 1'b0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        cfg_ready     = 1'b1;
        in_stall      = cfg_valid;
        cmd.cfg_write = cfg_valid;
        if (in_valid && !cfg_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        // result register free or being emptied this cycle
        if (!out_valid_r || !out_stall) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* rtl/fsa_dp.sv */
// Datapath: slot memories, free-chain head, config registers, result register.
`default_nettype none

module fsa_dp #(
  parameter int SLOTS = 256
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire fsa_pkg::fsa_cmd_t           cmd,
  input  wire [fsa_pkg::ACTION_W-1:0]      in_action,
  input  wire [fsa_pkg::INDEX_W-1:0]       in_slot_index,
  input  wire [fsa_pkg::LINK_W-1:0]        in_link_word,
  input  wire [fsa_pkg::RES_W-1:0]         in_resource_word,
  input  wire [fsa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [fsa_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic [fsa_pkg::STATUS_W-1:0]     out_status,
  output logic [fsa_pkg::GRANT_W-1:0]      out_granted_index,
  output logic [fsa_pkg::TAG_W-1:0]        out_granted_tag,
  output logic [fsa_pkg::LINK_W-1:0]       out_read_link,
  output logic [fsa_pkg::RES_W-1:0]        out_read_resource
);
  import fsa_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int HW = IW + 1;   // head and watermark reach SLOTS

  // Config registers
  logic [CAP_W-1:0] pool_cap_r;
  logic [TAG_W-1:0] tag_r;

  // Free chain head and pristine watermark: slots at or above the watermark
  // have not been popped since the last rebuild, so their link is index + 1
  // and they are free.
  logic [HW-1:0] head_r, head_nxt;
  logic [HW-1:0] wm_r, wm_nxt;

  // Captured transaction
  logic [ACTION_W-1:0] act_r;
  logic [INDEX_W-1:0]  idx_r;
  logic [LINK_W-1:0]   link_in_r;
  logic [RES_W-1:0]    res_in_r;

  // Slot memories and registered read data
  logic [HW-1:0]     nl_mem   [SLOTS];
  logic              used_mem [SLOTS];
  logic [LINK_W-1:0] link_mem [SLOTS];
  logic [RES_W-1:0]  res_mem  [SLOTS];
  logic [HW-1:0]     nl_rd_r;
  logic              used_rd_r;
  logic [LINK_W-1:0] link_rd_r;
  logic [RES_W-1:0]  res_rd_r;

  // Memory write controls
  logic              nl_we, used_we, pay_we;
  logic [IW-1:0]     wr_addr;
  logic [HW-1:0]     nl_wdata;
  logic              used_wdata;
  logic [LINK_W-1:0] link_wdata;
  logic [RES_W-1:0]  res_wdata;

  // Result values
  logic [STATUS_W-1:0] status_nxt;
  logic [GRANT_W-1:0]  gidx_nxt;
  logic [TAG_W-1:0]    gtag_nxt;
  logic [LINK_W-1:0]   rlink_nxt;
  logic [RES_W-1:0]    rres_nxt;

  // Compare terms
  logic [CMP_W-1:0] cap_eff;
  logic             idx_bad, head_full, idx_touched, head_touched, idx_used;

  assign cap_eff = (CMP_W'(pool_cap_r) > CMP_W'(SLOTS)) ? CMP_W'(SLOTS)
                                                         : CMP_W'(pool_cap_r);
  assign idx_bad      = CMP_W'(idx_r) >= cap_eff;
  assign head_full    = CMP_W'(head_r) >= cap_eff;
  assign idx_touched  = CMP_W'(idx_r) < CMP_W'(wm_r);
  assign head_touched = head_r < wm_r;
  assign idx_used     = idx_touched & used_rd_r;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_cap_r <= CAP_RESET;
      tag_r      <= TAG_RESET;
    end else if (cmd.cfg_write) begin
      case (cfg_index)
        CFG_CAPACITY: pool_cap_r <= cfg_wdata[CAP_W-1:0];
        CFG_TAG:      tag_r      <= cfg_wdata[TAG_W-1:0];
        default:      ;
      endcase
    end
  end

  // Head and watermark; a capacity write rebuilds the chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      wm_r   <= '0;
    end else if (cmd.cfg_write && cfg_index == CFG_CAPACITY) begin
      head_r <= '0;
      wm_r   <= '0;
    end else if (cmd.commit) begin
      head_r <= head_nxt;
      wm_r   <= wm_nxt;
    end
  end

  // Transaction capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r     <= in_action;
      idx_r     <= in_slot_index;
      link_in_r <= in_link_word;
      res_in_r  <= in_resource_word;
    end
  end

  // Next-link memory: read at the head on accept
  always_ff @(posedge clk) begin
    if (nl_we) begin
      nl_mem[wr_addr] <= nl_wdata;
    end
    if (cmd.accept) begin
      nl_rd_r <= nl_mem[head_r[IW-1:0]];
    end
  end

  // Used-flag memory: read at the handle on accept
  always_ff @(posedge clk) begin
    if (used_we) begin
      used_mem[wr_addr] <= used_wdata;
    end
    if (cmd.accept) begin
      used_rd_r <= used_mem[in_slot_index[IW-1:0]];
    end
  end

  // Payload memories
  always_ff @(posedge clk) begin
    if (pay_we) begin
      link_mem[wr_addr] <= link_wdata;
    end
    if (cmd.accept) begin
      link_rd_r <= link_mem[in_slot_index[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (pay_we) begin
      res_mem[wr_addr] <= res_wdata;
    end
    if (cmd.accept) begin
      res_rd_r <= res_mem[in_slot_index[IW-1:0]];
    end
  end

  // Transaction evaluation
  always_comb begin
    head_nxt   = head_r;
    wm_nxt     = wm_r;
    nl_we      = 1'b0;
    used_we    = 1'b0;
    pay_we     = 1'b0;
    wr_addr    = idx_r[IW-1:0];
    nl_wdata   = head_r;
    used_wdata = 1'b0;
    link_wdata = LINK_CLEARED;
    res_wdata  = RES_CLEARED;
    status_nxt = ST_OK;
    gidx_nxt   = '0;
    gtag_nxt   = '0;
    rlink_nxt  = '0;
    rres_nxt   = '0;
    case (act_r)
      ACT_CREATE: begin
        if (head_full) begin
          status_nxt = ST_FULL;
        end else begin
          // pop: pristine head links to its successor
          if (head_touched) begin
            head_nxt = nl_rd_r;
          end else begin
            head_nxt = head_r + HW'(1);
            wm_nxt   = wm_r + HW'(1);
          end
          used_we    = cmd.commit;
          pay_we     = cmd.commit;
          wr_addr    = head_r[IW-1:0];
          used_wdata = 1'b1;
          link_wdata = link_in_r;
          res_wdata  = res_in_r;
          gidx_nxt   = GRANT_W'(head_r);
          gtag_nxt   = tag_r;
        end
      end
      ACT_RELEASE: begin
        if (idx_bad) begin
          status_nxt = ST_RANGE;
        end else if (!idx_used) begin
          status_nxt = ST_FREE;
        end else begin
          // push onto the chain, clear payload
          nl_we    = cmd.commit;
          used_we  = cmd.commit;
          pay_we   = cmd.commit;
          head_nxt = HW'(idx_r);
        end
      end
      ACT_READ: begin
        if (idx_bad) begin
          status_nxt = ST_RANGE;
        end else begin
          rlink_nxt = link_rd_r;
          rres_nxt  = res_rd_r;
        end
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status        <= status_nxt;
      out_granted_index <= gidx_nxt;
      out_granted_tag   <= gtag_nxt;
      out_read_link     <= rlink_nxt;
      out_read_resource <= rres_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/free_list_slot_allocator.sv */
// Top level of the free-list slot allocator: controller plus datapath.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid / in_stall  action, slot_index, link_word, resource_word
//   out_     output     out_valid/out_stall  status, granted_index, granted_tag,
//                                            read_link, read_resource
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_wdata
//
// For each transaction, the accept cycle launches the synchronous
// memory reads (next link at the head, used flag and payload at the handle),
// and the S_EXEC state then evaluates and writes the slot memories.
// Reset needs no clearing pass: a watermark marks slots never popped since
// the last rebuild; a capacity write rebuilds the chain by clearing head and watermark.
// A stalled result is held in the output register; the evaluate cycle waits
// only while that register is full and stalled.
`default_nettype none

module free_list_slot_allocator #(
  parameter int SLOTS = 256
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire [fsa_pkg::ACTION_W-1:0]    in_action,
  input  wire [fsa_pkg::INDEX_W-1:0]     in_slot_index,
  input  wire [fsa_pkg::LINK_W-1:0]      in_link_word,
  input  wire [fsa_pkg::RES_W-1:0]       in_resource_word,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [fsa_pkg::STATUS_W-1:0]   out_status,
  output logic [fsa_pkg::GRANT_W-1:0]    out_granted_index,
  output logic [fsa_pkg::TAG_W-1:0]      out_granted_tag,
  output logic [fsa_pkg::LINK_W-1:0]     out_read_link,
  output logic [fsa_pkg::RES_W-1:0]      out_read_resource,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire [fsa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [fsa_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import fsa_pkg::*;

  fsa_cmd_t cmd;

  fsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  fsa_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_action         (in_action),
    .in_slot_index     (in_slot_index),
    .in_link_word      (in_link_word),
    .in_resource_word  (in_resource_word),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_granted_tag   (out_granted_tag),
    .out_read_link     (out_read_link),
    .out_read_resource (out_read_resource)
  );

  // One transaction in flight: an accept is followed by a stalled cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a transaction is in flight");

  // A new result appears only at the edge after the evaluate cycle of an accept
  a_result_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a preceding transaction");

  // Failed operations carry zero payload fields
  a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_granted_index == '0 && out_granted_tag == '0 &&
      out_read_link == '0 && out_read_resource == '0)
    else $error("error result with nonzero payload");

  // Config writes and item accepts never coincide
  a_cfg_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |-> in_stall)
    else $error("config write while accepting a transaction");

endmodule

`default_nettype wire

/* bench/tb_free_list_slot_allocator.sv */
// Self-checking testbench of the free-list slot allocator.
`default_nettype none

module tb_free_list_slot_allocator;
  import fsa_pkg::*;

  localparam int SLOTS          = 256;
  localparam int HOLD_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  // One result transaction
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [GRANT_W-1:0]  index;
    logic [TAG_W-1:0]    tag;
    logic [LINK_W-1:0]   link;
    logic [RES_W-1:0]    res;
  } reply_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [ACTION_W-1:0]   in_action = '0;
  logic [INDEX_W-1:0]    in_slot_index = '0;
  logic [LINK_W-1:0]     in_link_word = '0;
  logic [RES_W-1:0]      in_resource_word = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [GRANT_W-1:0]    out_granted_index;
  logic [TAG_W-1:0]      out_granted_tag;
  logic [LINK_W-1:0]     out_read_link;
  logic [RES_W-1:0]      out_read_resource;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  free_list_slot_allocator #(.SLOTS(SLOTS)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_slot_index     (in_slot_index),
    .in_link_word      (in_link_word),
    .in_resource_word  (in_resource_word),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_granted_tag   (out_granted_tag),
    .out_read_link     (out_read_link),
    .out_read_resource (out_read_resource),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // Predicted allocator state
  logic [CAP_W-1:0]  cap_reg;
  logic [TAG_W-1:0]  tag_reg;
  logic [CAP_W-1:0]  chain_head;
  logic [CAP_W-1:0]  chain_next [SLOTS];
  bit                slot_busy [SLOTS];
  bit                slot_filled [SLOTS];  // payload written since reset
  logic [LINK_W-1:0] link_mem [SLOTS];
  logic [RES_W-1:0]  res_mem [SLOTS];

  reply_t pending_replies[$];
  int     error_count = 0;
  bit     calm = 1'b0;       // no idling on either side
  bit     hold_req = 1'b0;
  int     hold_left = 0;
  int     idle_cycles = 0;

  // Clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int unsigned eff_cap();
    return (cap_reg > SLOTS) ? SLOTS : cap_reg;
  endfunction

  function automatic void rebuild_chain();
    chain_head = '0;
    for (int i = 0; i < SLOTS; i++) begin
      chain_next[i] = CAP_W'(i + 1);
      slot_busy[i] = 1'b0;
    end
  endfunction

  function automatic void reset_allocator_state();
    cap_reg = CAP_RESET;
    tag_reg = TAG_RESET;
    rebuild_chain();
    for (int i = 0; i < SLOTS; i++) begin
      slot_filled[i] = 1'b0;
      link_mem[i] = '0;
      res_mem[i] = '0;
    end
  endfunction

  // Expected reply of one transaction; updates the predicted pool
  function automatic reply_t allocator_predict(logic [ACTION_W-1:0] act,
                                               logic [INDEX_W-1:0] idx,
                                               logic [LINK_W-1:0] lw,
                                               logic [RES_W-1:0] rw);
    reply_t r;
    int unsigned cap;
    int unsigned s;
    r = '0;
    r.status = ST_OK;
    cap = eff_cap();
    case (act)
      ACT_CREATE: begin
        if (chain_head >= cap) begin
          r.status = ST_FULL;
        end else begin
          s = chain_head;
          chain_head = chain_next[s];
          slot_busy[s] = 1'b1;
          slot_filled[s] = 1'b1;
          link_mem[s] = lw;
          res_mem[s] = rw;
          r.index = s[GRANT_W-1:0];
          r.tag = tag_reg;
        end
      end
      ACT_RELEASE: begin
        if (idx >= cap) begin
          r.status = ST_RANGE;
        end else if (!slot_busy[idx]) begin
          r.status = ST_FREE;
        end else begin
          slot_busy[idx] = 1'b0;
          chain_next[idx] = chain_head;
          chain_head = idx[CAP_W-1:0];
          slot_filled[idx] = 1'b1;
          link_mem[idx] = LINK_CLEARED;
          res_mem[idx] = RES_CLEARED;
        end
      end
      ACT_READ: begin
        if (idx >= cap) begin
          r.status = ST_RANGE;
        end else begin
          r.link = link_mem[idx];
          r.res = res_mem[idx];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Random in-range slot that is allocated (busy_only) or holds a payload
  function automatic int pick_slot(bit busy_only);
    int n;
    int k;
    int unsigned cap;
    n = 0;
    cap = eff_cap();
    for (int i = 0; i < cap; i++)
      if (busy_only ? slot_busy[i] : slot_filled[i]) n++;
    if (n == 0) return -1;
    k = $urandom_range(n - 1, 0);
    for (int i = 0; i < cap; i++) begin
      if (busy_only ? slot_busy[i] : slot_filled[i]) begin
        if (k == 0) return i;
        k--;
      end
    end
    return -1;
  endfunction

  function automatic logic [INDEX_W-1:0] bad_index();
    return INDEX_W'($urandom_range(65535, eff_cap()));
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Offer one transaction, hold it until accepted, then predict its reply
  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [INDEX_W-1:0] idx,
                           input logic [LINK_W-1:0] lw, input logic [RES_W-1:0] rw);
    reply_t r;
    @(negedge clk);
    if (!calm && $urandom_range(99) < 28) begin
      in_valid = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_action = act;
    in_slot_index = idx;
    in_link_word = lw;
    in_resource_word = rw;
    do @(posedge clk); while (in_stall !== 1'b0);
    r = allocator_predict(act, idx, lw, rw);
    pending_replies.push_back(r);
  endtask

  // Sender goes quiet until every reply is back, then waits settle cycles
  task automatic wait_idle(input int settle);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_idle(4);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == CFG_CAPACITY) begin
      cap_reg = data[CAP_W-1:0];
      rebuild_chain();
    end else begin
      tag_reg = data[TAG_W-1:0];
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Capacity with random don't-care upper bits
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    logic [CFG_DATA_W-CAP_W-1:0] upper;
    upper = (CFG_DATA_W - CAP_W)'($urandom_range(2 ** (CFG_DATA_W - CAP_W) - 1, 0));
    write_reg(CFG_CAPACITY, {upper, cap});
  endtask

  // Mostly well-formed traffic: releases aim at allocated slots, reads at slots holding a payload
  task automatic random_item();
    int r;
    int s;
    int unsigned cap;
    logic [ACTION_W-1:0] act;
    logic [INDEX_W-1:0]  idx;
    logic [LINK_W-1:0]   lw;
    logic [RES_W-1:0]    rw;
    cap = eff_cap();
    lw = $urandom();
    rw = {$urandom(), $urandom()};
    idx = INDEX_W'($urandom_range(65535, 0));
    case ($urandom_range(9, 0))
      0: begin lw = '0; rw = '0; end
      1: begin lw = '1; rw = '1; end
      default: ;
    endcase
    r = $urandom_range(99, 0);
    if (r < 40) begin
      act = ACT_CREATE;
    end else if (r < 68) begin
      act = ACT_RELEASE;
      r = $urandom_range(99, 0);
      if (r < 70) begin
        s = pick_slot(1'b1);
        idx = (s < 0) ? bad_index() : s[INDEX_W-1:0];
      end else if (r < 85 && cap != 0) begin
        idx = INDEX_W'($urandom_range(cap - 1, 0));
      end else begin
        idx = bad_index();
      end
    end else if (r < 95) begin
      act = ACT_READ;
      s = (($urandom_range(99, 0) < 75)) ? pick_slot(1'b0) : -1;
      idx = (s < 0) ? bad_index() : s[INDEX_W-1:0];
    end else begin
      act = ACT_UNUSED;
    end
    send_item(act, idx, lw, rw);
  endtask

  // Receiver: random stalls, calm stretches, and a long counted hold-off
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall = 1'b1;
    end else if (calm) begin
      out_stall = 1'b0;
    end else begin
      out_stall = ($urandom_range(99, 0) < 28);
    end
  end

  // Result checker
  always @(posedge clk) begin
    reply_t exp_r;
    reply_t got_r;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      got_r = '{out_status, out_granted_index, out_granted_tag, out_read_link,
                out_read_resource};
      if (pending_replies.size() == 0) begin
        report_error($sformatf("%0t: unexpected result status=%0d index=%0d", $realtime,
                               got_r.status, got_r.index));
      end else begin
        exp_r = pending_replies.pop_front();
        if (got_r !== exp_r)
          report_error($sformatf({"%0t: mismatch\n  exp status=%0d index=%0d tag=%h ",
                                  "link=%h res=%h\n  got status=%0d index=%0d tag=%h ",
                                  "link=%h res=%h"}, $realtime,
                                 exp_r.status, exp_r.index, exp_r.tag, exp_r.link, exp_r.res,
                                 got_r.status, got_r.index, got_r.tag, got_r.link, got_r.res));
      end
    end
  end

  // Watchdog: cycles without any transaction on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("free_list_slot_allocator regression: fail");
      $finish;
    end
  end

  // Default pool: grant order, readback, release clearing, double release
  task automatic test_basic_ops();
    send_item(ACT_CREATE, '0, '0, '0);
    send_item(ACT_CREATE, '1, '1, '1);
    send_item(ACT_CREATE, 16'h0002, 32'h8000_0001, 64'h8000_0000_0000_0001);
    send_item(ACT_READ, 16'd0, '0, '0);
    send_item(ACT_READ, 16'd1, '1, '1);
    send_item(ACT_RELEASE, 16'd1, '0, '0);
    send_item(ACT_READ, 16'd1, '0, '0);
    send_item(ACT_RELEASE, 16'd1, '0, '0);
    send_item(ACT_CREATE, '0, 32'h1234_5678, 64'h0123_4567_89AB_CDEF);
    send_item(ACT_RELEASE, 16'd256, '0, '0);
    send_item(ACT_READ, 16'hFFFF, '0, '0);
    send_item(ACT_RELEASE, 16'd255, '0, '0);
    send_item(ACT_UNUSED, '1, '1, '1);
  endtask

  // Two-slot pool: full pool, reads past capacity
  task automatic test_small_pool();
    write_reg(CFG_CAPACITY, 16'hFE02);
    write_reg(CFG_TAG, 16'hFFFF);
    send_item(ACT_CREATE, '0, 32'hA5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A);
    send_item(ACT_CREATE, '0, 32'h0F0F_0F0F, 64'hF0F0_F0F0_F0F0_F0F0);
    send_item(ACT_CREATE, '0, '1, '1);
    send_item(ACT_RELEASE, 16'd0, '0, '0);
    send_item(ACT_READ, 16'd0, '0, '0);
    send_item(ACT_READ, 16'd2, '0, '0);
  endtask

  // Empty pool and capacity above the slot count
  task automatic test_capacity_extremes();
    write_capacity(9'd0);
    send_item(ACT_CREATE, '0, '1, '1);
    send_item(ACT_RELEASE, 16'd0, '0, '0);
    write_capacity(9'd511);
    write_reg(CFG_TAG, 16'h5A5A);
    send_item(ACT_CREATE, '0, 32'hDEAD_BEEF, 64'hFEED_FACE_CAFE_F00D);
    send_item(ACT_READ, 16'd0, '0, '0);
  endtask

  // Long receiver hold-off while the sender keeps offering, then a drain pause
  task automatic test_backpressure();
    write_capacity(9'd8);
    calm = 1'b1;
    hold_req = 1'b1;
    repeat (16) random_item();
    calm = 1'b0;
    wait_idle(0);
    repeat (4) random_item();
  endtask

  // Phases of random traffic over several capacity and tag settings
  task automatic test_random_traffic();
    logic [CAP_W-1:0] cap;
    logic [TAG_W-1:0] tag;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: cap = 9'd1;
        1: cap = 9'd256;
        2: cap = CAP_W'($urandom_range(16, 2));
        3: cap = 9'd3;
        4: cap = 9'd511;
        5: cap = CAP_W'($urandom_range(64, 1));
        6: cap = 9'd2;
        default: cap = CAP_W'($urandom_range(256, 1));
      endcase
      case (ph)
        0: tag = 16'hFFFF;
        1: tag = 16'h0000;
        default: tag = TAG_W'($urandom_range(65535, 0));
      endcase
      write_capacity(cap);
      write_reg(CFG_TAG, tag);
      calm = (ph == 2);
      for (int n = 0; n < 100; n++) begin
        if (ph == 5 && n == 50) wait_idle(0);
        random_item();
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    reset_allocator_state();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_basic_ops();
    test_small_pool();
    test_capacity_extremes();
    test_backpressure();
    test_random_traffic();

    wait_idle(16);
    if (error_count == 0 && pending_replies.size() == 0) begin
      $display("free_list_slot_allocator regression: pass");
    end else begin
      $display("free_list_slot_allocator regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
